FILE: hw/rtl/ulte_pkg.sv
// Shared constants and command/status codes for the unsorted list table engine.
`default_nettype none
package ulte_pkg;
    localparam int CAPACITY    = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RETRIEVE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE_ONE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE_ALL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REWIND     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_NEXT  = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_PAST_END = 2'd3;
endpackage
`default_nettype wire

FILE: hw/rtl/ulte_if.sv
// Valid/ready channel interfaces for command and result beats.
`default_nettype none
interface ulte_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [ulte_pkg::CMD_W-1:0]      command;
    logic [ulte_pkg::VALUE_WIDTH-1:0] item_value;

    modport source (output valid, output command, output item_value, input ready);
    modport sink   (input valid, input command, input item_value, output ready);
endinterface

interface ulte_res_if;
    logic                             valid;
    logic                             ready;
    logic [ulte_pkg::STATUS_W-1:0]    status;
    logic                             found;
    logic [ulte_pkg::VALUE_WIDTH-1:0] result_value;
    logic [ulte_pkg::CNT_W-1:0]       entry_count;
    logic                             is_full;

    modport source (output valid, output status, output found, output result_value,
                    output entry_count, output is_full, input ready);
    modport sink   (input valid, input status, input found, input result_value,
                    input entry_count, input is_full, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/unsorted_list_table_engine_top.sv
// Unsorted list table engine: table memory, scan sequencer and result register.
// Each command beat yields exactly one result beat. Insert, rewind, unused codes and a
// refused read are answered from idle; read next goes through one registered memory read.
// Retrieve and delete-first compare one entry per cycle through a single comparator and
// memory read port, and a delete adds a move state that writes the last entry into the
// hole. Delete-all passes through the move state once per removed entry. The command side
// is not ready while a command is in work; the next command is taken no earlier than the
// cycle in which the previous result beat leaves the output register.
`default_nettype none
module unsorted_list_table_engine_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ulte_cmd_if.sink      cmd,
    ulte_res_if.source    res
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_MOVE = 2'd2;
    localparam logic [1:0] ST_READ = 2'd3;

    logic [1:0]                        state_reg, state_next;
    logic [ulte_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [ulte_pkg::CNT_W-1:0]        cursor_reg, cursor_next;
    logic [ulte_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic [ulte_pkg::CMD_W-1:0]        cmd_reg, cmd_next;
    logic [ulte_pkg::VALUE_WIDTH-1:0]  value_reg, value_next;
    logic                              hit_reg, hit_next;

    logic [ulte_pkg::VALUE_WIDTH-1:0]  mem [ulte_pkg::CAPACITY];
    logic [ulte_pkg::VALUE_WIDTH-1:0]  rd_data_reg;
    logic                              rd_en;
    logic [ulte_pkg::IDX_W-1:0]        rd_addr;
    logic                              wr_en;
    logic [ulte_pkg::IDX_W-1:0]        wr_addr;
    logic [ulte_pkg::VALUE_WIDTH-1:0]  wr_data;

    logic                              res_valid_reg, res_valid_next;
    logic [ulte_pkg::STATUS_W-1:0]     status_reg;
    logic                              found_reg;
    logic [ulte_pkg::VALUE_WIDTH-1:0]  result_value_reg;
    logic [ulte_pkg::CNT_W-1:0]        entry_count_reg;
    logic                              is_full_reg;

    logic                              res_load;
    logic [ulte_pkg::STATUS_W-1:0]     res_status;
    logic                              res_found;
    logic [ulte_pkg::VALUE_WIDTH-1:0]  res_value;

    logic                              cmd_ready;
    logic                              cmd_beat;
    logic [ulte_pkg::CNT_W-1:0]        cnt_dec;
    logic [ulte_pkg::CNT_W-1:0]        idx_inc;
    logic [ulte_pkg::CNT_W-1:0]        idx_ext;
    logic                              match;
    logic                              table_full;

    assign cmd_ready  = (state_reg == ST_IDLE) && (!res_valid_reg || res.ready);
    assign cmd_beat   = cmd.valid && cmd_ready;
    assign cmd.ready  = cmd_ready;
    assign cnt_dec    = count_reg - ulte_pkg::CNT_W'(1);
    assign idx_ext    = {1'b0, idx_reg};
    assign idx_inc    = idx_ext + ulte_pkg::CNT_W'(1);
    assign match      = (rd_data_reg == value_reg);
    assign table_full = (count_reg == ulte_pkg::CNT_W'(ulte_pkg::CAPACITY));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        idx_next    = idx_reg;
        cmd_next    = cmd_reg;
        value_next  = value_reg;
        hit_next    = hit_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = rd_data_reg;
        res_load    = 1'b0;
        res_status  = ulte_pkg::STATUS_OK;
        res_found   = 1'b0;
        res_value   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_beat)
                begin
                    cmd_next   = cmd.command;
                    value_next = cmd.item_value;
                    hit_next   = 1'b0;
                    idx_next   = '0;
                    unique case (cmd.command)
                        ulte_pkg::CMD_INSERT:
                        begin
                            res_load = 1'b1;
                            if (table_full)
                            begin
                                res_status = ulte_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[ulte_pkg::IDX_W-1:0];
                                wr_data    = cmd.item_value;
                                count_next = count_reg + ulte_pkg::CNT_W'(1);
                            end
                        end
                        ulte_pkg::CMD_RETRIEVE, ulte_pkg::CMD_DELETE_ONE,
                        ulte_pkg::CMD_DELETE_ALL:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load   = 1'b1;
                                res_status = ulte_pkg::STATUS_NO_MATCH;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        ulte_pkg::CMD_REWIND:
                        begin
                            cursor_next = '0;
                            res_load    = 1'b1;
                        end
                        ulte_pkg::CMD_READ_NEXT:
                        begin
                            if (cursor_reg < count_reg)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = cursor_reg[ulte_pkg::IDX_W-1:0];
                                state_next = ST_READ;
                            end
                            else
                            begin
                                res_load   = 1'b1;
                                res_status = ulte_pkg::STATUS_PAST_END;
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (match && cmd_reg == ulte_pkg::CMD_RETRIEVE)
                begin
                    res_load   = 1'b1;
                    res_found  = 1'b1;
                    res_value  = rd_data_reg;
                    state_next = ST_IDLE;
                end
                else if (match)
                begin
                    hit_next   = 1'b1;
                    rd_en      = 1'b1;
                    rd_addr    = cnt_dec[ulte_pkg::IDX_W-1:0];
                    state_next = ST_MOVE;
                end
                else if (idx_inc < count_reg)
                begin
                    idx_next = idx_inc[ulte_pkg::IDX_W-1:0];
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc[ulte_pkg::IDX_W-1:0];
                end
                else
                begin
                    res_load   = 1'b1;
                    res_status = hit_reg ? ulte_pkg::STATUS_OK : ulte_pkg::STATUS_NO_MATCH;
                    res_found  = hit_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_MOVE:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = rd_data_reg;
                count_next = cnt_dec;
                if (cmd_reg == ulte_pkg::CMD_DELETE_ALL && idx_ext < cnt_dec)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    res_load   = 1'b1;
                    res_found  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                res_load    = 1'b1;
                res_value   = rd_data_reg;
                cursor_next = cursor_reg + ulte_pkg::CNT_W'(1);
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            idx_reg       <= '0;
            cmd_reg       <= ulte_pkg::CMD_INSERT;
            hit_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            idx_reg       <= idx_next;
            cmd_reg       <= cmd_next;
            hit_reg       <= hit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (res_load)
        begin
            status_reg       <= res_status;
            found_reg        <= res_found;
            result_value_reg <= res_value;
            entry_count_reg  <= count_next;
            is_full_reg      <= (count_next == ulte_pkg::CNT_W'(ulte_pkg::CAPACITY));
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.status       = status_reg;
    assign res.found        = found_reg;
    assign res.result_value = result_value_reg;
    assign res.entry_count  = entry_count_reg;
    assign res.is_full      = is_full_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/ulte_checker.sv
// Port-level checker for the unsorted list table engine and its bind.
`default_nettype none
module ulte_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             res_valid,
    input wire logic                             res_ready,
    input wire logic [ulte_pkg::STATUS_W-1:0]    status,
    input wire logic                             found,
    input wire logic [ulte_pkg::VALUE_WIDTH-1:0] result_value,
    input wire logic [ulte_pkg::CNT_W-1:0]       entry_count,
    input wire logic                             is_full
);
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status) && $stable(found)
            && $stable(result_value) && $stable(entry_count))
        else $error("result beat changed while stalled");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (is_full == (entry_count == ulte_pkg::CNT_W'(ulte_pkg::CAPACITY))))
        else $error("full flag disagrees with entry count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> entry_count <= ulte_pkg::CNT_W'(ulte_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && found |-> status == ulte_pkg::STATUS_OK)
        else $error("found flag with error status");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != ulte_pkg::STATUS_OK |-> !found && result_value == '0)
        else $error("refused command carries data");
endmodule

bind unsorted_list_table_engine_top ulte_checker u_ulte_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .status       (res.status),
    .found        (res.found),
    .result_value (res.result_value),
    .entry_count  (res.entry_count),
    .is_full      (res.is_full)
);
`default_nettype wire

FILE: sim/unsorted_list_table_engine_top_test.sv
// Self-checking testbench for the unsorted list table engine: directed, random and stall tests.
`default_nettype none
module unsorted_list_table_engine_top_test;
    localparam logic [ulte_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [ulte_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam int IDLE_LIMIT    = 4000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 2 * ulte_pkg::CAPACITY + 16;

    typedef struct packed {
        logic [ulte_pkg::STATUS_W-1:0]    status;
        logic                             found;
        logic [ulte_pkg::VALUE_WIDTH-1:0] value;
        logic [ulte_pkg::CNT_W-1:0]       count;
        logic                             full;
    } table_result_t;

    typedef enum int {STALL_NONE, STALL_HALF, STALL_RARE, STALL_HEAVY} stall_pattern_t;

    logic clk = 1'b0;
    logic rst_n;

    ulte_cmd_if cmd_ch ();
    ulte_res_if res_ch ();

    unsorted_list_table_engine_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    always #10 clk = ~clk;

    logic [ulte_pkg::VALUE_WIDTH-1:0] model_entries [ulte_pkg::CAPACITY];
    int unsigned                      model_count;
    int unsigned                      model_cursor;
    table_result_t                    expected_results [$];
    logic [ulte_pkg::VALUE_WIDTH-1:0] value_pool [8];
    int                               burst_left;
    int                               hold_requests;
    int                               failures;

    function automatic table_result_t predict_command(
        input logic [ulte_pkg::CMD_W-1:0] op,
        input logic [ulte_pkg::VALUE_WIDTH-1:0] val);
        table_result_t r;
        int unsigned   i;
        r        = '0;
        r.status = ulte_pkg::STATUS_OK;
        unique case (op)
            ulte_pkg::CMD_INSERT:
            begin
                if (model_count >= ulte_pkg::CAPACITY)
                begin
                    r.status = ulte_pkg::STATUS_FULL;
                end
                else
                begin
                    model_entries[model_count] = val;
                    model_count++;
                end
            end
            ulte_pkg::CMD_RETRIEVE:
            begin
                r.status = ulte_pkg::STATUS_NO_MATCH;
                for (i = 0; i < model_count && !r.found; i++)
                begin
                    if (model_entries[i] == val)
                    begin
                        r.status = ulte_pkg::STATUS_OK;
                        r.found  = 1'b1;
                        r.value  = model_entries[i];
                    end
                end
            end
            ulte_pkg::CMD_DELETE_ONE:
            begin
                r.status = ulte_pkg::STATUS_NO_MATCH;
                for (i = 0; i < model_count && !r.found; i++)
                begin
                    if (model_entries[i] == val)
                    begin
                        model_entries[i] = model_entries[model_count - 1];
                        model_count--;
                        r.status = ulte_pkg::STATUS_OK;
                        r.found  = 1'b1;
                    end
                end
            end
            ulte_pkg::CMD_DELETE_ALL:
            begin
                r.status = ulte_pkg::STATUS_NO_MATCH;
                i = 0;
                while (i < model_count)
                begin
                    if (model_entries[i] == val)
                    begin
                        model_entries[i] = model_entries[model_count - 1];
                        model_count--;
                        r.status = ulte_pkg::STATUS_OK;
                        r.found  = 1'b1;
                    end
                    else
                    begin
                        i++;
                    end
                end
            end
            ulte_pkg::CMD_REWIND:
            begin
                model_cursor = 0;
            end
            ulte_pkg::CMD_READ_NEXT:
            begin
                if (model_cursor < model_count)
                begin
                    r.value = model_entries[model_cursor];
                    model_cursor++;
                end
                else
                begin
                    r.status = ulte_pkg::STATUS_PAST_END;
                end
            end
            default:
            begin
            end
        endcase
        r.count = model_count[ulte_pkg::CNT_W-1:0];
        r.full  = (model_count == ulte_pkg::CAPACITY);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    task automatic send_command(input logic [ulte_pkg::CMD_W-1:0] op,
                                input logic [ulte_pkg::VALUE_WIDTH-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= op;
        cmd_ch.item_value <= val;
        do @(posedge clk); while (!cmd_ch.ready);
        expected_results.push_back(predict_command(op, val));
    endtask

    task automatic wait_drain();
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    task automatic refresh_pool();
        int i;
        for (i = 0; i < 8; i++)
        begin
            value_pool[i] = $urandom();
        end
        value_pool[$urandom_range(0, 7)] = '0;
        value_pool[$urandom_range(0, 7)] = '1;
    endtask

    function automatic logic [ulte_pkg::VALUE_WIDTH-1:0] pick_value();
        if ($urandom_range(0, 9) < 6)
        begin
            return value_pool[$urandom_range(0, 7)];
        end
        return $urandom();
    endfunction

    function automatic logic [ulte_pkg::CMD_W-1:0] pick_command();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return ulte_pkg::CMD_INSERT;
        if (roll < 45) return ulte_pkg::CMD_RETRIEVE;
        if (roll < 60) return ulte_pkg::CMD_DELETE_ONE;
        if (roll < 68) return ulte_pkg::CMD_DELETE_ALL;
        if (roll < 73) return ulte_pkg::CMD_REWIND;
        if (roll < 95) return ulte_pkg::CMD_READ_NEXT;
        if (roll < 98) return CMD_SPARE_LO;
        return CMD_SPARE_HI;
    endfunction

    task automatic test_empty_table();
        send_command(ulte_pkg::CMD_READ_NEXT, '0);
        send_command(ulte_pkg::CMD_RETRIEVE, '0);
        send_command(ulte_pkg::CMD_DELETE_ONE, '1);
        send_command(ulte_pkg::CMD_DELETE_ALL, '0);
        send_command(ulte_pkg::CMD_REWIND, '1);
        send_command(CMD_SPARE_LO, '1);
        send_command(CMD_SPARE_HI, '0);
    endtask

    task automatic test_extreme_values();
        int n;
        send_command(ulte_pkg::CMD_INSERT, '0);
        send_command(ulte_pkg::CMD_INSERT, '1);
        send_command(ulte_pkg::CMD_INSERT, 32'h8000_0001);
        send_command(ulte_pkg::CMD_RETRIEVE, '1);
        send_command(ulte_pkg::CMD_RETRIEVE, 32'h1234_5678);
        send_command(ulte_pkg::CMD_REWIND, '0);
        for (n = 0; n < 4; n++)
        begin
            send_command(ulte_pkg::CMD_READ_NEXT, $urandom());
        end
        send_command(ulte_pkg::CMD_DELETE_ONE, '0);
        send_command(ulte_pkg::CMD_READ_NEXT, '1);
    endtask

    task automatic test_delete_all_recheck();
        send_command(ulte_pkg::CMD_INSERT, 32'd7);
        send_command(ulte_pkg::CMD_INSERT, 32'd7);
        send_command(ulte_pkg::CMD_INSERT, 32'd3);
        send_command(ulte_pkg::CMD_INSERT, 32'd7);
        send_command(ulte_pkg::CMD_DELETE_ALL, 32'd7);
        send_command(ulte_pkg::CMD_RETRIEVE, 32'd3);
    endtask

    task automatic test_random_mix();
        int seg;
        int n;
        for (seg = 0; seg < 4; seg++)
        begin
            refresh_pool();
            for (n = 0; n < 320; n++)
            begin
                send_command(pick_command(), pick_value());
            end
        end
    endtask

    task automatic test_fill_and_drain();
        int round;
        int n;
        for (round = 0; round < 3; round++)
        begin
            refresh_pool();
            for (n = 0; n < ulte_pkg::CAPACITY + 2; n++)
            begin
                send_command(ulte_pkg::CMD_INSERT, pick_value());
            end
            send_command(ulte_pkg::CMD_REWIND, $urandom());
            for (n = 0; n <= ulte_pkg::CAPACITY; n++)
            begin
                send_command(ulte_pkg::CMD_READ_NEXT, $urandom());
            end
            while (model_count > 0)
            begin
                send_command(($urandom_range(0, 3) == 0) ? ulte_pkg::CMD_DELETE_ALL
                                                         : ulte_pkg::CMD_DELETE_ONE,
                             model_entries[$urandom_range(0, model_count - 1)]);
            end
            send_command(ulte_pkg::CMD_READ_NEXT, $urandom());
        end
    endtask

    task automatic test_backpressure();
        int round;
        int n;
        for (round = 0; round < 3; round++)
        begin
            refresh_pool();
            hold_requests <= hold_requests + 1;
            for (n = 0; n < 50; n++)
            begin
                send_command(pick_command(), pick_value());
            end
            wait_drain();
        end
    endtask

    initial
    begin
        stall_pattern_t pattern;
        int             pattern_left;
        int             hold_left;
        int             holds_served;
        pattern_left = 0;
        hold_left    = 0;
        holds_served = 0;
        pattern      = STALL_NONE;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern      = stall_pattern_t'($urandom_range(0, 3));
                    pattern_left = $urandom_range(8, 80);
                end
                pattern_left--;
                unique case (pattern)
                    STALL_NONE:  res_ch.ready <= 1'b1;
                    STALL_HALF:  res_ch.ready <= ($urandom_range(0, 1) == 0);
                    STALL_RARE:  res_ch.ready <= ($urandom_range(0, 9) != 0);
                    default:     res_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        table_result_t want;
        if (res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with no command outstanding");
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", 64'(want.status), 64'(res_ch.status));
                check_field("found", 64'(want.found), 64'(res_ch.found));
                check_field("result_value", 64'(want.value), 64'(res_ch.result_value));
                check_field("entry_count", 64'(want.count), 64'(res_ch.entry_count));
                check_field("is_full", 64'(want.full), 64'(res_ch.is_full));
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int i;
        cmd_ch.valid      = 1'b0;
        cmd_ch.command    = ulte_pkg::CMD_REWIND;
        cmd_ch.item_value = '0;
        rst_n             = 1'b0;
        for (i = 0; i < ulte_pkg::CAPACITY; i++)
        begin
            model_entries[i] = '0;
        end
        model_count   = 0;
        model_cursor  = 0;
        burst_left    = 0;
        hold_requests = 0;
        failures      = 0;
        refresh_pool();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_extreme_values();
        test_delete_all_recheck();
        test_random_mix();
        test_fill_and_drain();
        test_backpressure();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
hw/rtl/ulte_pkg.sv
hw/rtl/ulte_if.sv
hw/rtl/unsorted_list_table_engine_top.sv
hw/rtl/ulte_checker.sv
sim/unsorted_list_table_engine_top_test.sv
